@@ hw/rtl/key_edge_repeat_double_press_unit_assert.svh @@
// Assertion macros used by the RTL file of the key edge, repeat and double-press unit.
`ifndef KEY_EDGE_REPEAT_DOUBLE_PRESS_UNIT_ASSERT_SVH
`define KEY_EDGE_REPEAT_DOUBLE_PRESS_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define KEDP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define KEDP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define KEDP_ASSERT(lbl, clk, rstn, prop, msg)
`define KEDP_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

@@ hw/rtl/kedp_pkg.sv @@
`default_nettype none

package kedp_pkg;

  localparam int unsigned NUM_KEYS   = 256;
  localparam int unsigned COUNT_BITS = 8;

  localparam int unsigned KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned CMP_W  = (COUNT_BITS > 8) ? COUNT_BITS : 8;

  localparam logic [8:0] KEY_LIMIT = 9'(NUM_KEYS);

  localparam logic [7:0] REPEAT_DELAY_RST  = 8'd30;
  localparam logic [7:0] DOUBLE_WINDOW_RST = 8'd20;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 1'b1;

  typedef struct packed {
    logic [7:0] key_index;
    logic       key_level;
    logic       sample_valid;
  } in_t;

  typedef struct packed {
    logic [7:0] key_id;
    logic       held;
    logic       press_edge;
    logic       release_edge;
    logic       repeat_pulse;
    logic       double_press;
  } out_t;

  typedef struct packed {
    logic                  prev_level;
    logic                  press_flag;
    logic                  release_flag;
    logic                  repeat_flag;
    logic                  double_flag;
    logic [COUNT_BITS-1:0] hold_count;
    logic [COUNT_BITS-1:0] window_count;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

endpackage

`default_nettype wire

@@ hw/rtl/key_edge_repeat_double_press_unit.sv @@
// A result beat passes the stage-1 register and then the output register.
// Throughput: one beat per cycle unless stalled; each key record lives in one RAM
// read on accept and written back as stage 1 advances, with one-deep forwarding.
// Reset: per-entry valid flops clear at once so every record reads as zero,
// delay and window registers load 30 and 20, and no clearing pass is run.
`default_nettype none

`include "key_edge_repeat_double_press_unit_assert.svh"

module key_edge_repeat_double_press_unit import kedp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_t                   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_t                       out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers.
  logic [7:0] repeat_delay_q;
  logic [7:0] double_window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_delay_q  <= REPEAT_DELAY_RST;
      double_window_q <= DOUBLE_WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REPEAT_DELAY:  repeat_delay_q  <= cfg_data_i;
        REG_DOUBLE_WINDOW: double_window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake and stage control.
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv;
  logic in_acc;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  logic [KEY_AW-1:0] in_addr;
  logic              in_range;
  assign in_addr  = in_data_i.key_index[KEY_AW-1:0];
  assign in_range = ({1'b0, in_data_i.key_index} < KEY_LIMIT);

  // Stage 1 payload.
  logic [7:0]        s1_key_q;
  logic [KEY_AW-1:0] s1_addr_q;
  logic              s1_level_q;
  logic              s1_sample_q;
  logic              s1_range_q;
  logic              s1_rd_vld_q;
  logic              fwd_hit_q, fwd_hit_d;
  rec_t              fwd_rec_q;

  logic [NUM_KEYS-1:0] entry_vld_q;

  logic              mem_we;
  rec_t              new_rec;
  logic [REC_W-1:0]  mem_rdata;

  assign mem_we    = s1_valid_q && s1_adv && s1_range_q && s1_sample_q;
  // A write at the same edge as the next read of that key is not seen by that read.
  assign fwd_hit_d = mem_we && (s1_addr_q == in_addr);

  assign s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = (s1_valid_q && s1_adv) ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      entry_vld_q <= '0;
      fwd_hit_q   <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (mem_we) begin
        entry_vld_q[s1_addr_q] <= 1'b1;
      end
      if (in_acc) begin
        fwd_hit_q <= fwd_hit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_key_q    <= in_data_i.key_index;
      s1_addr_q   <= in_addr;
      s1_level_q  <= in_data_i.key_level;
      s1_sample_q <= in_data_i.sample_valid;
      s1_range_q  <= in_range;
      s1_rd_vld_q <= entry_vld_q[in_addr];
      fwd_rec_q   <= new_rec;
    end
  end

  kedp_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_KEYS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (s1_addr_q),
    .wdata_i (new_rec),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (mem_rdata)
  );

  // Record update.
  rec_t                  cur_rec;
  rec_t                  upd_rec;
  logic [COUNT_BITS-1:0] hold_inc;
  logic [COUNT_BITS-1:0] win_inc;

  assign cur_rec  = fwd_hit_q ? fwd_rec_q : (s1_rd_vld_q ? rec_t'(mem_rdata) : '0);
  assign hold_inc = cur_rec.hold_count + COUNT_BITS'(1);
  assign win_inc  = cur_rec.window_count + COUNT_BITS'(1);

  always_comb begin
    upd_rec              = cur_rec;
    upd_rec.press_flag   = s1_level_q && !cur_rec.prev_level;
    upd_rec.release_flag = cur_rec.prev_level && !s1_level_q;
    upd_rec.prev_level   = s1_level_q;

    if (s1_level_q) begin
      if (CMP_W'(cur_rec.hold_count) < CMP_W'(repeat_delay_q)) begin
        upd_rec.hold_count  = hold_inc;
        upd_rec.repeat_flag = (hold_inc == COUNT_BITS'(1)) ||
                              (CMP_W'(hold_inc) >= CMP_W'(repeat_delay_q));
      end
    end else begin
      upd_rec.repeat_flag = 1'b0;
      upd_rec.hold_count  = '0;
    end

    if (cur_rec.window_count != '0) begin
      upd_rec.window_count = win_inc;
      if (upd_rec.press_flag) begin
        upd_rec.double_flag  = s1_level_q;
        upd_rec.window_count = '0;
      end
      if (CMP_W'(upd_rec.window_count) >= CMP_W'(double_window_q)) begin
        upd_rec.window_count = '0;
      end
    end else if (upd_rec.press_flag) begin
      upd_rec.window_count = COUNT_BITS'(1);
    end else begin
      upd_rec.double_flag = 1'b0;
    end
  end

  // An invalid sample keeps the record and reports what is stored.
  assign new_rec = s1_sample_q ? upd_rec : cur_rec;

  // Output register.
  out_t out_data_q, out_data_d;

  always_comb begin
    out_data_d.key_id = s1_key_q;
    if (s1_range_q) begin
      out_data_d.held         = new_rec.prev_level;
      out_data_d.press_edge   = new_rec.press_flag;
      out_data_d.release_edge = new_rec.release_flag;
      out_data_d.repeat_pulse = new_rec.repeat_flag;
      out_data_d.double_press = new_rec.double_flag;
    end else begin
      out_data_d.held         = 1'b0;
      out_data_d.press_edge   = 1'b0;
      out_data_d.release_edge = 1'b0;
      out_data_d.repeat_pulse = 1'b0;
      out_data_d.double_press = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `KEDP_ASSERT(a_acc_fills_s1, clk_i, rst_ni, in_acc |=> s1_valid_q, "accepted beat lost")
  `KEDP_ASSERT(a_s1_holds, clk_i, rst_ni,
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_key_q)), "stalled stage changed")
  `KEDP_ASSERT_NEVER(a_edges_excl, clk_i, rst_ni,
    out_valid_o && out_data_o.press_edge && out_data_o.release_edge,
    "press and release edge together")

endmodule

`default_nettype wire

@@ hw/rtl/kedp_ram.sv @@
`default_nettype none

module kedp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
